// ===== rtl/pidtb_pkg.sv =====
package pidtb_pkg;

  // Field widths
  localparam int SPEED_W  = 16;
  localparam int ANGLE_W  = 15;
  localparam int GAIN_W   = 16;
  localparam int CMD_W    = 13;
  localparam int STEER_W  = 14;
  localparam int ERR_W    = 17;
  localparam int DER_W    = 18;
  localparam int SUM_W    = 32;

  // Stream packing
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // Serial multiply-accumulate unit: one multiplier bit per cycle
  localparam int MUL_STEPS = 17;
  localparam int CNT_W     = $clog2(MUL_STEPS);
  localparam int OPD_W     = 33;
  localparam int HI_W      = 35;
  localparam int PROD_W    = HI_W + MUL_STEPS;

  // Rounding positions
  localparam int PID_SHIFT   = 8;
  localparam int PID_W       = PROD_W - PID_SHIFT;
  localparam int BRK_SHIFT   = 12;
  localparam int STEER_SHIFT = 16;

  // Brake magnitude is saturated here; anything larger clamps anyway
  localparam int MAG_W       = 25;
  localparam int BRK_PROD_W  = MAG_W + GAIN_W;
  localparam int BRK_W       = BRK_PROD_W - BRK_SHIFT + 1;
  localparam int STEER_RAW_W = PROD_W - STEER_SHIFT;

  // 180 / (35 * pi) in Q.16
  localparam logic [MUL_STEPS-1:0] STEER_SCALE = 17'd107284;
  localparam logic [CMD_W-1:0]     FULL_CMD    = 13'd4096;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_SPEED = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_BRK_BAND  = 3'd4,
    REG_BRK_SCALE = 3'd5,
    REG_BRK_CEIL  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [SPEED_W-1:0] set_speed;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [SPEED_W-1:0] brk_band;
    logic [GAIN_W-1:0]  brk_scale;
    logic [CMD_W-1:0]   brk_ceil;
  } cfg_regs_t;

endpackage

// ===== rtl/pid_throttle_brake_controller_unit.sv =====
// PID speed controller with throttle/brake split and normalized steering.
//
// Input stream (s_axis_*): one item per control tick carrying the measured
// speed and the steering angle. Output stream (m_axis_*): one item per
// input item with throttle, brake and steer commands.
// Configuration channel (cfg_*): writes one register per item by index;
// always ready. Write only while no tick is in flight.
//
// Each tick takes two passes of the shared bit-serial multiply-accumulate
// unit (PID sum, then brake scaling), each with a load step; the steer
// product runs on a second serial unit during the first pass. A new item
// is accepted the cycle after the result is loaded into the output
// register, so one tick finishes its passes before the next item is
// taken.
//
// Reset clears the integral and previous error and loads the default
// register values. If the receiver stalls, the finished result holds in
// the output register; a following item may be accepted and computed, and
// it then waits for the output register before it is written.
module pid_throttle_brake_controller_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] measured_speed, [30:16] steer_angle, [31] zero
  input  logic [pidtb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [12:0] throttle, [25:13] brake, [39:26] steer
  output logic [pidtb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pidtb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidtb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pidtb_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_PID, ST_RND, ST_BRK, ST_OUT} state_t;

  state_t                     state;
  cfg_regs_t                  regs;
  logic                       accept;

  logic [SPEED_W-1:0]         speed;
  logic signed [ANGLE_W-1:0]  angle;

  logic signed [SUM_W-1:0]    error_sum;
  logic signed [ERR_W-1:0]    last_error;
  logic                       brk_en;
  logic signed [PID_W-1:0]    pid;

  logic signed [ERR_W-1:0]    err_c;
  logic signed [SUM_W:0]      sum_wide;
  logic signed [SUM_W-1:0]    sum_next;
  logic signed [DER_W-1:0]    der_c;
  logic signed [ERR_W:0]      db_c;

  logic signed [PID_W:0]      neg_pid;
  logic [MAG_W-1:0]           mag_c;
  logic                       pid_pos;
  logic signed [PID_W-1:0]    full_pid;

  logic                       a_start, a_done, b_done;
  logic [MUL_STEPS-1:0]       a_mult_a, a_mult_b, a_mult_c;
  logic signed [OPD_W-1:0]    a_opd_a, a_opd_b, a_opd_c, b_opd_a;
  logic signed [PROD_W-1:0]   prod_a, prod_b;

  logic [BRK_W-1:0]           brk_raw;
  logic [CMD_W-1:0]           brk_lim;
  logic [CMD_W-1:0]           thr_c, brk_c;
  logic signed [STEER_RAW_W-1:0] st_raw;
  logic signed [STEER_W-1:0]  st_c;
  logic signed [STEER_RAW_W-1:0] st_max, st_min;

  logic [CMD_W-1:0]           out_throttle, out_brake;
  logic signed [STEER_W-1:0]  out_steer;

  pidtb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign speed         = s_axis_tdata[SPEED_W-1:0];
  assign angle         = s_axis_tdata[SPEED_W+ANGLE_W-1:SPEED_W];

  // Error, saturating integral, derivative and deadband test
  always_comb begin
    err_c    = $signed({1'b0, regs.set_speed}) - $signed({1'b0, speed});
    sum_wide = {error_sum[SUM_W-1], error_sum}
             + {{(SUM_W+1-ERR_W){err_c[ERR_W-1]}}, err_c};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
    der_c = {err_c[ERR_W-1], err_c} - {last_error[ERR_W-1], last_error};
    db_c  = {err_c[ERR_W-1], err_c} + $signed({2'b00, regs.brk_band});
  end

  // Brake magnitude from the rounded PID sum, saturated
  always_comb begin
    neg_pid  = -{pid[PID_W-1], pid};
    mag_c    = (neg_pid[PID_W-1:MAG_W] != '0) ? {MAG_W{1'b1}} : neg_pid[MAG_W-1:0];
    pid_pos  = !pid[PID_W-1] && (pid != '0);
    full_pid = {{(PID_W-CMD_W){1'b0}}, FULL_CMD};
  end

  // Operand selection for the shared unit: PID pass, then brake pass
  always_comb begin
    a_start = accept || (state == ST_RND);
    if (state == ST_RND) begin
      a_mult_a = {1'b0, regs.brk_scale};
      a_mult_b = '0;
      a_mult_c = '0;
      a_opd_a  = {{(OPD_W-MAG_W){1'b0}}, mag_c};
      a_opd_b  = '0;
      a_opd_c  = '0;
    end else begin
      a_mult_a = {1'b0, regs.gain_p};
      a_mult_b = {1'b0, regs.gain_i};
      a_mult_c = {1'b0, regs.gain_d};
      a_opd_a  = {{(OPD_W-ERR_W){err_c[ERR_W-1]}}, err_c};
      a_opd_b  = {{(OPD_W-SUM_W){sum_next[SUM_W-1]}}, sum_next};
      a_opd_c  = {{(OPD_W-DER_W){der_c[DER_W-1]}}, der_c};
    end
    b_opd_a = {{(OPD_W-ANGLE_W){angle[ANGLE_W-1]}}, angle};
  end

  pidtb_smac u_mac_pid (
    .clk    (clk),
    .rst    (rst),
    .start  (a_start),
    .mult_a (a_mult_a),
    .mult_b (a_mult_b),
    .mult_c (a_mult_c),
    .opd_a  (a_opd_a),
    .opd_b  (a_opd_b),
    .opd_c  (a_opd_c),
    .done   (a_done),
    .prod   (prod_a)
  );

  pidtb_smac u_mac_steer (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .mult_a (STEER_SCALE),
    .mult_b ('0),
    .mult_c ('0),
    .opd_a  (b_opd_a),
    .opd_b  ('0),
    .opd_c  ('0),
    .done   (b_done),
    .prod   (prod_b)
  );

  // Final commands: throttle clamp, brake round and clamp, steer round and clamp
  always_comb begin
    thr_c   = '0;
    brk_c   = '0;
    brk_raw = {1'b0, prod_a[BRK_PROD_W-1:BRK_SHIFT]}
            + {{(BRK_W-1){1'b0}}, prod_a[BRK_SHIFT-1]};
    brk_lim = (regs.brk_ceil > FULL_CMD) ? FULL_CMD : regs.brk_ceil;
    if (pid_pos) begin
      thr_c = (pid > full_pid) ? FULL_CMD : pid[CMD_W-1:0];
    end else if (brk_en) begin
      brk_c = (brk_raw > {{(BRK_W-CMD_W){1'b0}}, brk_lim}) ? brk_lim : brk_raw[CMD_W-1:0];
    end
    st_max = {{(STEER_RAW_W-CMD_W){1'b0}}, FULL_CMD};
    st_min = -st_max;
    st_raw = $signed(prod_b[PROD_W-1:STEER_SHIFT])
           + $signed({{(STEER_RAW_W-1){1'b0}}, prod_b[STEER_SHIFT-1]});
    priority if (st_raw > st_max) begin
      st_c = st_max[STEER_W-1:0];
    end else if (st_raw < st_min) begin
      st_c = st_min[STEER_W-1:0];
    end else begin
      st_c = st_raw[STEER_W-1:0];
    end
  end

  // Sequencer, controller state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      error_sum     <= '0;
      last_error    <= '0;
      brk_en        <= 1'b0;
    end else begin
      // Drop valid once taken, unless a new result is loaded this cycle
      if (m_axis_tvalid && m_axis_tready && (state != ST_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            error_sum  <= sum_next;
            last_error <= err_c;
            brk_en     <= db_c[ERR_W];
            state      <= ST_PID;
          end
        end
        ST_PID: begin
          if (a_done) begin
            pid   <= $signed(prod_a[PROD_W-1:PID_SHIFT])
                   + $signed({{(PID_W-1){1'b0}}, prod_a[PID_SHIFT-1]});
            state <= ST_RND;
          end
        end
        ST_RND: begin
          state <= ST_BRK;
        end
        ST_BRK: begin
          if (a_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_throttle  <= thr_c;
            out_brake     <= brk_c;
            out_steer     <= st_c;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {out_steer, out_brake, out_throttle};

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == ST_PID))
    else $error("accepted item did not start the PID pass");

  a_thr_brk_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_throttle == '0 || out_brake == '0))
    else $error("throttle and brake both active");

  a_steer_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_steer <= $signed(14'sd4096) && out_steer >= $signed(-14'sd4096)))
    else $error("steer command out of range");

  a_steer_done: assert property (@(posedge clk) disable iff (rst)
    b_done |-> (state == ST_PID))
    else $error("steer pass finished outside the PID pass");

endmodule

// ===== rtl/pidtb_smac.sv =====
module pidtb_smac (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [pidtb_pkg::MUL_STEPS-1:0]     mult_a,
  input  logic [pidtb_pkg::MUL_STEPS-1:0]     mult_b,
  input  logic [pidtb_pkg::MUL_STEPS-1:0]     mult_c,
  input  logic signed [pidtb_pkg::OPD_W-1:0]  opd_a,
  input  logic signed [pidtb_pkg::OPD_W-1:0]  opd_b,
  input  logic signed [pidtb_pkg::OPD_W-1:0]  opd_c,
  output logic                                done,
  output logic signed [pidtb_pkg::PROD_W-1:0] prod
);
  import pidtb_pkg::*;

  logic                       run;
  logic [CNT_W-1:0]           cnt;
  logic [MUL_STEPS-1:0]       ma, mb, mc;
  logic signed [OPD_W-1:0]    oa, ob, oc;
  logic signed [HI_W-1:0]     hi;
  logic [MUL_STEPS-1:0]       lo;
  logic signed [HI_W-1:0]     pa, pb, pc, sum_t;

  // Select the partial products for the current multiplier bit
  always_comb begin
    pa    = ma[0] ? {{(HI_W-OPD_W){oa[OPD_W-1]}}, oa} : '0;
    pb    = mb[0] ? {{(HI_W-OPD_W){ob[OPD_W-1]}}, ob} : '0;
    pc    = mc[0] ? {{(HI_W-OPD_W){oc[OPD_W-1]}}, oc} : '0;
    sum_t = hi + pa + pb + pc;
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift multipliers right, shift product bits into the low register
  always_ff @(posedge clk) begin
    if (start) begin
      ma <= mult_a;
      mb <= mult_b;
      mc <= mult_c;
      oa <= opd_a;
      ob <= opd_b;
      oc <= opd_c;
      hi <= '0;
      lo <= '0;
    end else if (run) begin
      ma <= ma >> 1;
      mb <= mb >> 1;
      mc <= mc >> 1;
      hi <= sum_t >>> 1;
      lo <= {sum_t[0], lo[MUL_STEPS-1:1]};
    end
  end

  assign prod = {hi, lo};

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(run))
    else $error("smac done without a running pass");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start |=> run)
    else $error("smac start did not begin a pass");

  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(run) |-> done)
    else $error("smac pass ended without done");

endmodule

// ===== rtl/pidtb_regs.sv =====
module pidtb_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pidtb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidtb_pkg::CFG_DATA_W-1:0] cfg_data,
  output pidtb_pkg::cfg_regs_t             regs
);
  import pidtb_pkg::*;

  assign cfg_ready = 1'b1;

  // Write one register per accepted item; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.set_speed <= 16'd3840;
      regs.gain_p    <= 16'd3072;
      regs.gain_i    <= 16'd123;
      regs.gain_d    <= 16'd2253;
      regs.brk_band  <= 16'd26;
      regs.brk_scale <= 16'd1229;
      regs.brk_ceil  <= 13'd2048;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SET_SPEED: regs.set_speed <= cfg_data;
        REG_GAIN_P:    regs.gain_p    <= cfg_data;
        REG_GAIN_I:    regs.gain_i    <= cfg_data;
        REG_GAIN_D:    regs.gain_d    <= cfg_data;
        REG_BRK_BAND:  regs.brk_band  <= cfg_data;
        REG_BRK_SCALE: regs.brk_scale <= cfg_data;
        REG_BRK_CEIL:  regs.brk_ceil  <= cfg_data[CMD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
